[hw/rtl/cpc_pkg.sv]
// ----------------------------------------------------------------------------
// cpc_pkg: shared definitions of the character page composer
// Field widths, action and status codes, the special name table and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package cpc_pkg;

    localparam int POS_W     = 24;
    localparam int SCALE_W   = 16;
    localparam int CHAR_W    = 8;
    localparam int ACT_W     = 4;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 8;

    localparam int DEF_PAGE_ROWS   = 100;
    localparam int DEF_PAGE_COLS   = 100;
    localparam int DEF_STACK_DEPTH = 5;
    localparam int DEF_ROW_CUT     = 78;

    localparam logic [SCALE_W-1:0] COL_SCALE_RST = 16'd75;
    localparam logic [SCALE_W-1:0] ROW_SCALE_RST = 16'd100;

    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;

    localparam logic [CFG_IDX_W-1:0] CFG_COL_SCALE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_SCALE = 8'd1;

    localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STS_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] STS_UNDERFLOW = 2'd2;

    typedef enum logic [ACT_W-1:0] {
        ACT_HGOTO     = 4'd0,
        ACT_HMOVE     = 4'd1,
        ACT_VGOTO     = 4'd2,
        ACT_VMOVE     = 4'd3,
        ACT_PUT_CHAR  = 4'd4,
        ACT_PUT_SPEC  = 4'd5,
        ACT_LINE_END  = 4'd6,
        ACT_PUSH      = 4'd7,
        ACT_POP       = 4'd8,
        ACT_NEW_PAGE  = 4'd9,
        ACT_READ_NEXT = 4'd10
    } act_t;

    typedef struct packed {
        logic              found;
        logic [CHAR_W-1:0] ch;
    } spec_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic idle;
        logic exec_simple;
        logic div_start;
        logic div_row;
        logic latch_col;
        logic latch_row;
        logic write_char;
        logic clear_start;
        logic clear_step;
        logic read_start;
        logic scan_init;
        logic scan_rd;
        logic scan_step;
        logic limit_hit;
        logic limit_zero;
        logic fetch_rd;
        logic emit_char;
        logic emit_nl;
        logic emit_empty;
        logic load_out;
    } cpc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        act_t act;
        logic in_valid;
        logic out_free;
        logic div_done;
        logic output_on;
        logic special_found;
        logic read_active;
        logic box_empty;
        logic col_lt_limit;
        logic last_row;
        logic scan_hit;
        logic scan_at_min;
        logic clear_last;
    } cpc_sts_t;

    // Two-letter special names and the character each one stores.
    function automatic spec_t special_lookup(input logic [CHAR_W-1:0] n1,
                                             input logic [CHAR_W-1:0] n2);
        spec_t r;
        r.found = 1'b1;
        r.ch    = CHAR_SPACE;
        case ({n1, n2})
            "em", "hy", "en": r.ch = "-";
            "bu":             r.ch = "o";
            "mu":             r.ch = "x";
            "sq":             r.ch = "]";
            "ru":             r.ch = "_";
            "l.":             r.ch = ".";
            "br", "vr", "or": r.ch = "|";
            "fm":             r.ch = "'";
            "pl":             r.ch = "+";
            "ci":             r.ch = "O";
            "**":             r.ch = "*";
            default:          r.found = 1'b0;
        endcase
        return r;
    endfunction

endpackage

[hw/rtl/cpc_if.sv]
// ----------------------------------------------------------------------------
// cpc_if: channel interfaces of the character page composer
// Action channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface cpc_in_if
    import cpc_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [ACT_W-1:0]          action;
    logic signed [POS_W-1:0]   amount;
    logic [CHAR_W-1:0]         char_code;
    logic [CHAR_W-1:0]         name_first;
    logic [CHAR_W-1:0]         name_second;

    modport source (output valid, action, amount, char_code, name_first, name_second,
                    input ready);
    modport sink   (input valid, action, amount, char_code, name_first, name_second,
                    output ready);
endinterface

interface cpc_out_if
    import cpc_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [CHAR_W-1:0]   out_char;
    logic                out_valid;
    logic                end_of_row;
    logic                end_of_page;

    modport source (output valid, status, out_char, out_valid, end_of_row, end_of_page,
                    input ready);
    modport sink   (input valid, status, out_char, out_valid, end_of_row, end_of_page,
                    output ready);
endinterface

interface cpc_cfg_if
    import cpc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [SCALE_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/cpc_div.sv]
// ----------------------------------------------------------------------------
// cpc_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle; a zero divisor acts as one.
// ----------------------------------------------------------------------------
module cpc_div
    import cpc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [POS_W-1:0]   dividend,
    input  logic [SCALE_W-1:0] divisor,
    output logic               done,
    output logic [POS_W-1:0]   quotient
);

    localparam int CNT_W = $clog2(POS_W + 1);

    logic [POS_W-1:0]   q_reg, q_next;
    logic [SCALE_W-1:0] r_reg, r_next;
    logic [SCALE_W-1:0] d_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [SCALE_W:0]   rem_sh;
    logic [SCALE_W:0]   diff;
    logic               ge;

    always_comb
    begin
        rem_sh = {r_reg, q_reg[POS_W-1]};
        ge     = rem_sh >= {1'b0, d_reg};
        diff   = rem_sh - {1'b0, d_reg};
        r_next = ge ? diff[SCALE_W-1:0] : rem_sh[SCALE_W-1:0];
        q_next = {q_reg[POS_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(POS_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= (divisor == '0) ? SCALE_W'(1) : divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

[hw/rtl/cpc_ctrl.sv]
// ----------------------------------------------------------------------------
// cpc_ctrl: controller of the character page composer
// Sequences clearing, divisions, store writes, row scans and result hand-off.
// ----------------------------------------------------------------------------
module cpc_ctrl
    import cpc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cpc_sts_t sts,
    output cpc_cmd_t cmd
);

    typedef enum logic [10:0] {
        ST_CLEAR      = 11'b00000000001,
        ST_IDLE       = 11'b00000000010,
        ST_DECODE     = 11'b00000000100,
        ST_DIV_COL    = 11'b00000001000,
        ST_DIV_ROW    = 11'b00000010000,
        ST_WRITE      = 11'b00000100000,
        ST_SCAN_RD    = 11'b00001000000,
        ST_SCAN_CHK   = 11'b00010000000,
        ST_FETCH      = 11'b00100000000,
        ST_FETCH_WAIT = 11'b01000000000,
        ST_DONE       = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic   clr_item_reg, clr_item_next;
    logic   emit_after_reg, emit_after_next;

    always_comb
    begin
        state_next      = state_reg;
        clr_item_next   = clr_item_reg;
        emit_after_next = emit_after_reg;
        cmd             = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last)
                    state_next = clr_item_reg ? ST_DONE : ST_IDLE;
            end
            ST_IDLE:
            begin
                cmd.idle = 1'b1;
                if (sts.in_valid)
                    state_next = ST_DECODE;
            end
            ST_DECODE:
            begin
                state_next = ST_DONE;
                unique case (sts.act)
                    ACT_PUT_CHAR, ACT_PUT_SPEC:
                    begin
                        if (sts.output_on && (sts.act == ACT_PUT_CHAR || sts.special_found))
                        begin
                            cmd.div_start = 1'b1;
                            state_next    = ST_DIV_COL;
                        end
                    end
                    ACT_NEW_PAGE:
                    begin
                        cmd.clear_start = 1'b1;
                        clr_item_next   = 1'b1;
                        state_next      = ST_CLEAR;
                    end
                    ACT_READ_NEXT:
                    begin
                        if (!sts.read_active)
                        begin
                            if (sts.box_empty)
                                cmd.emit_empty = 1'b1;
                            else
                            begin
                                cmd.read_start  = 1'b1;
                                cmd.scan_init   = 1'b1;
                                emit_after_next = 1'b1;
                                state_next      = ST_SCAN_RD;
                            end
                        end
                        else if (sts.col_lt_limit)
                            state_next = ST_FETCH;
                        else
                        begin
                            cmd.emit_nl = 1'b1;
                            if (!sts.last_row)
                            begin
                                cmd.scan_init   = 1'b1;
                                emit_after_next = 1'b0;
                                state_next      = ST_SCAN_RD;
                            end
                        end
                    end
                    default:
                        cmd.exec_simple = 1'b1;
                endcase
            end
            ST_DIV_COL:
            begin
                if (sts.div_done)
                begin
                    cmd.latch_col = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_row   = 1'b1;
                    state_next    = ST_DIV_ROW;
                end
            end
            ST_DIV_ROW:
            begin
                if (sts.div_done)
                begin
                    cmd.latch_row = 1'b1;
                    state_next    = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                cmd.write_char = 1'b1;
                state_next     = ST_DONE;
            end
            ST_SCAN_RD:
            begin
                cmd.scan_rd = 1'b1;
                state_next  = ST_SCAN_CHK;
            end
            ST_SCAN_CHK:
            begin
                if (sts.scan_hit || sts.scan_at_min)
                begin
                    cmd.limit_hit  = sts.scan_hit;
                    cmd.limit_zero = !sts.scan_hit;
                    state_next     = emit_after_reg ? ST_DECODE : ST_DONE;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                    state_next    = ST_SCAN_RD;
                end
            end
            ST_FETCH:
            begin
                cmd.fetch_rd = 1'b1;
                state_next   = ST_FETCH_WAIT;
            end
            ST_FETCH_WAIT:
            begin
                cmd.emit_char = 1'b1;
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out  = 1'b1;
                    clr_item_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_item_reg   <= 1'b0;
            emit_after_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_item_reg   <= clr_item_next;
            emit_after_reg <= emit_after_next;
        end
    end

endmodule

[hw/rtl/cpc_dp.sv]
// ----------------------------------------------------------------------------
// cpc_dp: datapath of the character page composer
// Position, stack, bounding box, page store, read cursor and result register.
// ----------------------------------------------------------------------------
module cpc_dp
    import cpc_pkg::*;
#(
    parameter int PAGE_ROWS   = DEF_PAGE_ROWS,
    parameter int PAGE_COLS   = DEF_PAGE_COLS,
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int ROW_CUT     = DEF_ROW_CUT
)
(
    input  logic          clk,
    input  logic          rst_n,
    cpc_in_if.sink        item,
    cpc_out_if.source     result,
    cpc_cfg_if.sink       cfg,
    input  cpc_cmd_t      cmd,
    output cpc_sts_t      sts
);

    localparam int MEM_DEPTH = PAGE_ROWS * PAGE_COLS;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int ROW_W     = $clog2(PAGE_ROWS + 1);
    localparam int COL_W     = $clog2(PAGE_COLS + 1);
    localparam int LIM_W     = $clog2(ROW_CUT + 2);
    localparam int SUM_W     = $clog2(PAGE_COLS + ROW_CUT + 2);
    localparam int SL_W      = $clog2(STACK_DEPTH + 1);
    localparam int SI_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    // Latched action.
    act_t               act_reg;
    logic [POS_W-1:0]   amt_reg;
    logic [CHAR_W-1:0]  ch_reg;
    spec_t              spec_reg;

    logic [SCALE_W-1:0] col_scale_reg;
    logic [SCALE_W-1:0] row_scale_reg;

    logic [POS_W-1:0]   col_pos_reg;
    logic [POS_W-1:0]   row_pos_reg;
    logic [SL_W-1:0]    stack_level_reg;
    logic [2*POS_W-1:0] stack_mem [STACK_DEPTH];
    logic               output_on_reg;

    logic [COL_W-1:0]   box_min_col_reg, box_max_col_reg;
    logic [ROW_W-1:0]   box_min_row_reg, box_max_row_reg;
    logic [COL_W-1:0]   put_col_reg;
    logic [ROW_W-1:0]   put_row_reg;

    logic               read_active_reg;
    logic [ROW_W-1:0]   read_row_reg;
    logic [LIM_W-1:0]   read_col_reg;
    logic [LIM_W-1:0]   read_limit_reg;
    logic [COL_W-1:0]   scan_col_reg;

    logic [ADDR_W-1:0]  clr_addr_reg;

    logic [CHAR_W-1:0]  page_mem [MEM_DEPTH];
    logic [CHAR_W-1:0]  rd_data_reg;

    logic [STATUS_W-1:0] res_status_reg;
    logic [CHAR_W-1:0]   res_char_reg;
    logic                res_ov_reg, res_eor_reg, res_eop_reg;

    logic                out_vld_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [CHAR_W-1:0]   out_char_reg;
    logic                out_ov_reg, out_eor_reg, out_eop_reg;

    // Divider hookup.
    logic               div_done;
    logic [POS_W-1:0]   quotient;
    logic [POS_W-1:0]   div_pos;
    logic               div_neg_reg;
    logic [COL_W-1:0]   col_idx;
    logic [ROW_W-1:0]   row_idx;

    logic [ADDR_W-1:0]  mem_addr;
    logic               mem_we;
    logic [CHAR_W-1:0]  mem_wdata;
    logic [CHAR_W-1:0]  put_char;

    logic [SUM_W-1:0]   cut_hi, k_cut, lim_val, fsum;
    logic [COL_W-1:0]   fetch_col;
    logic [SI_W-1:0]    push_idx, pop_idx;
    logic               in_accept;

    assign in_accept  = cmd.idle && item.valid;
    assign item.ready = cmd.idle;
    assign cfg.ready  = 1'b1;

    cpc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_pos),
        .divisor  (cmd.div_row ? row_scale_reg : col_scale_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign div_pos = cmd.div_row ? row_pos_reg : col_pos_reg;

    // Negative positions clamp to zero, large quotients to the last cell.
    always_comb
    begin
        if (div_neg_reg)
            col_idx = '0;
        else if (quotient >= POS_W'(PAGE_COLS))
            col_idx = COL_W'(PAGE_COLS - 1);
        else
            col_idx = COL_W'(quotient);
        if (div_neg_reg)
            row_idx = '0;
        else if (quotient >= POS_W'(PAGE_ROWS))
            row_idx = ROW_W'(PAGE_ROWS - 1);
        else
            row_idx = ROW_W'(quotient);
    end

    always_comb
    begin
        cut_hi    = SUM_W'(box_min_col_reg) + SUM_W'(ROW_CUT);
        k_cut     = (SUM_W'(scan_col_reg) > cut_hi) ? cut_hi : SUM_W'(scan_col_reg);
        lim_val   = k_cut - SUM_W'(box_min_col_reg) + SUM_W'(1);
        fsum      = SUM_W'(box_min_col_reg) + SUM_W'(read_col_reg);
        fetch_col = (fsum >= SUM_W'(PAGE_COLS)) ? COL_W'(PAGE_COLS - 1) : COL_W'(fsum);
        push_idx  = SI_W'(stack_level_reg);
        pop_idx   = SI_W'(stack_level_reg - SL_W'(1));
        put_char  = (act_reg == ACT_PUT_CHAR) ? ch_reg : spec_reg.ch;
    end

    // Single store port: clearing sweep, put, row scan and character fetch.
    always_comb
    begin
        mem_we    = cmd.clear_step || cmd.write_char;
        mem_wdata = cmd.clear_step ? CHAR_SPACE : put_char;
        priority if (cmd.clear_step)
            mem_addr = clr_addr_reg;
        else if (cmd.write_char)
            mem_addr = ADDR_W'(put_row_reg) * ADDR_W'(PAGE_COLS) + ADDR_W'(put_col_reg);
        else if (cmd.scan_rd)
            mem_addr = ADDR_W'(read_row_reg) * ADDR_W'(PAGE_COLS) + ADDR_W'(scan_col_reg);
        else
            mem_addr = ADDR_W'(read_row_reg) * ADDR_W'(PAGE_COLS) + ADDR_W'(fetch_col);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            page_mem[mem_addr] <= mem_wdata;
        rd_data_reg <= page_mem[mem_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec_simple && act_reg == ACT_PUSH && stack_level_reg < SL_W'(STACK_DEPTH))
            stack_mem[push_idx] <= {col_pos_reg, row_pos_reg};
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            act_reg  <= act_t'(item.action);
            amt_reg  <= item.amount;
            ch_reg   <= item.char_code;
            spec_reg <= special_lookup(item.name_first, item.name_second);
        end
        if (cmd.div_start)
            div_neg_reg <= div_pos[POS_W-1];
        if (cmd.latch_col)
            put_col_reg <= col_idx;
        if (cmd.latch_row)
            put_row_reg <= row_idx;
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_char_reg   <= res_char_reg;
            out_ov_reg     <= res_ov_reg;
            out_eor_reg    <= res_eor_reg;
            out_eop_reg    <= res_eop_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_scale_reg   <= COL_SCALE_RST;
            row_scale_reg   <= ROW_SCALE_RST;
            col_pos_reg     <= '0;
            row_pos_reg     <= '0;
            stack_level_reg <= '0;
            output_on_reg   <= 1'b0;
            box_min_col_reg <= COL_W'(PAGE_COLS);
            box_max_col_reg <= '0;
            box_min_row_reg <= ROW_W'(PAGE_ROWS);
            box_max_row_reg <= '0;
            read_active_reg <= 1'b0;
            read_row_reg    <= '0;
            read_col_reg    <= '0;
            read_limit_reg  <= '0;
            scan_col_reg    <= '0;
            clr_addr_reg    <= '0;
            res_status_reg  <= STS_OK;
            res_char_reg    <= '0;
            res_ov_reg      <= 1'b0;
            res_eor_reg     <= 1'b0;
            res_eop_reg     <= 1'b0;
            out_vld_reg     <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.index == CFG_COL_SCALE)
                col_scale_reg <= cfg.data;
            if (cfg.valid && cfg.index == CFG_ROW_SCALE)
                row_scale_reg <= cfg.data;

            if (in_accept)
            begin
                res_status_reg <= STS_OK;
                res_char_reg   <= '0;
                res_ov_reg     <= 1'b0;
                res_eor_reg    <= 1'b0;
                res_eop_reg    <= 1'b0;
            end

            if (cmd.exec_simple)
            begin
                unique case (act_reg)
                    ACT_HGOTO:    col_pos_reg <= amt_reg;
                    ACT_HMOVE:    col_pos_reg <= col_pos_reg + amt_reg;
                    ACT_VGOTO:    row_pos_reg <= amt_reg;
                    ACT_VMOVE:    row_pos_reg <= row_pos_reg + amt_reg;
                    ACT_LINE_END: col_pos_reg <= '0;
                    ACT_PUSH:
                    begin
                        if (stack_level_reg >= SL_W'(STACK_DEPTH))
                            res_status_reg <= STS_OVERFLOW;
                        else
                        begin
                            stack_level_reg <= stack_level_reg + SL_W'(1);
                            col_pos_reg     <= '0;
                            row_pos_reg     <= '0;
                        end
                    end
                    ACT_POP:
                    begin
                        if (stack_level_reg == '0)
                            res_status_reg <= STS_UNDERFLOW;
                        else
                        begin
                            stack_level_reg <= stack_level_reg - SL_W'(1);
                            {col_pos_reg, row_pos_reg} <= stack_mem[pop_idx];
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (cmd.write_char)
            begin
                if (put_col_reg > box_max_col_reg)
                    box_max_col_reg <= put_col_reg;
                if (put_col_reg < box_min_col_reg)
                    box_min_col_reg <= put_col_reg;
                if (put_row_reg > box_max_row_reg)
                    box_max_row_reg <= put_row_reg;
                if (put_row_reg < box_min_row_reg)
                    box_min_row_reg <= put_row_reg;
            end

            if (cmd.clear_start)
            begin
                col_pos_reg     <= '0;
                row_pos_reg     <= '0;
                box_min_col_reg <= COL_W'(PAGE_COLS);
                box_max_col_reg <= '0;
                box_min_row_reg <= ROW_W'(PAGE_ROWS);
                box_max_row_reg <= '0;
                output_on_reg   <= 1'b1;
                read_active_reg <= 1'b0;
                read_row_reg    <= '0;
                read_col_reg    <= '0;
                read_limit_reg  <= '0;
                clr_addr_reg    <= '0;
            end
            if (cmd.clear_step)
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);

            if (cmd.read_start)
            begin
                read_active_reg <= 1'b1;
                read_row_reg    <= box_min_row_reg;
                read_col_reg    <= '0;
            end
            if (cmd.scan_init)
                scan_col_reg <= box_max_col_reg;
            if (cmd.scan_step)
                scan_col_reg <= scan_col_reg - COL_W'(1);
            if (cmd.limit_hit)
                read_limit_reg <= LIM_W'(lim_val);
            if (cmd.limit_zero)
                read_limit_reg <= '0;

            if (cmd.emit_char)
            begin
                res_char_reg <= rd_data_reg;
                res_ov_reg   <= 1'b1;
                read_col_reg <= read_col_reg + LIM_W'(1);
            end
            if (cmd.emit_nl)
            begin
                res_char_reg <= CHAR_NEWLINE;
                res_eor_reg  <= 1'b1;
                read_col_reg <= '0;
                if (read_row_reg >= box_max_row_reg)
                begin
                    res_eop_reg     <= 1'b1;
                    read_active_reg <= 1'b0;
                    read_row_reg    <= '0;
                    read_limit_reg  <= '0;
                end
                else
                    read_row_reg <= read_row_reg + ROW_W'(1);
            end
            if (cmd.emit_empty)
                res_eop_reg <= 1'b1;

            if (cmd.load_out)
                out_vld_reg <= 1'b1;
            else if (result.ready)
                out_vld_reg <= 1'b0;
        end
    end

    assign result.valid       = out_vld_reg;
    assign result.status      = out_status_reg;
    assign result.out_char    = out_char_reg;
    assign result.out_valid   = out_ov_reg;
    assign result.end_of_row  = out_eor_reg;
    assign result.end_of_page = out_eop_reg;

    always_comb
    begin
        sts.act           = act_reg;
        sts.in_valid      = item.valid;
        sts.out_free      = !out_vld_reg || result.ready;
        sts.div_done      = div_done;
        sts.output_on     = output_on_reg;
        sts.special_found = spec_reg.found;
        sts.read_active   = read_active_reg;
        sts.box_empty     = box_min_row_reg > box_max_row_reg;
        sts.col_lt_limit  = read_col_reg < read_limit_reg;
        sts.last_row      = read_row_reg >= box_max_row_reg;
        sts.scan_hit      = rd_data_reg != CHAR_SPACE;
        sts.scan_at_min   = scan_col_reg == box_min_col_reg;
        sts.clear_last    = clr_addr_reg == ADDR_W'(MEM_DEPTH - 1);
    end

endmodule

[hw/rtl/character_page_composer_core.sv]
// ----------------------------------------------------------------------------
// character_page_composer_core: top level of the character page composer
// Places characters into a character-cell page store and streams the
// bounding box of the page back out, one character or newline at a time.
// ----------------------------------------------------------------------------
//
//   channel  | role   | handshake    | payload
//   ---------+--------+--------------+------------------------------------------
//   item     | sink   | valid, ready | action, amount, char_code, name_first/2nd
//   result   | source | valid, ready | status, out_char, out_valid, end_of_row,
//            |        |              | end_of_page
//   cfg      | sink   | valid, ready | index, data (col_scale, row_scale)
//
// Every transaction on item gives exactly one transaction on result.
// Moves, push, pop and unused actions are done in the decode state. A put
// makes two passes through the shared iterative divider, column then row.
// A read of a character is one store fetch; the first read of a page and
// each newline but the last of the page add a backward scan of the row to
// be read next, cell by cell from the right edge of the box.
// After reset and on each new page a clearing sweep writes PAGE_ROWS*PAGE_COLS
// cells, one per cycle (10000 cells by default); item is not taken meanwhile.
// A stalled result is held in the output register while the next transaction
// on item is already taken and worked on.
//
module character_page_composer_core
    import cpc_pkg::*;
#(
    parameter int PAGE_ROWS   = DEF_PAGE_ROWS,
    parameter int PAGE_COLS   = DEF_PAGE_COLS,
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int ROW_CUT     = DEF_ROW_CUT
)
(
    input  logic       clk,
    input  logic       rst_n,
    cpc_in_if.sink     item,
    cpc_out_if.source  result,
    cpc_cfg_if.sink    cfg
);

    // Commands and status between the controller and the datapath.
    cpc_cmd_t cmd;
    cpc_sts_t sts;

    // The controller holds the sequence of every action; the datapath
    // holds all architectural state, the page store and the divider.
    cpc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    cpc_dp #(
        .PAGE_ROWS   (PAGE_ROWS),
        .PAGE_COLS   (PAGE_COLS),
        .STACK_DEPTH (STACK_DEPTH),
        .ROW_CUT     (ROW_CUT)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result),
        .cfg    (cfg),
        .cmd    (cmd),
        .sts    (sts)
    );

`ifndef SYNTHESIS
    // Once a transaction is taken, the block is busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && item.ready |=> !item.ready)
        else $error("item taken while previous action still in progress");

    // A page character is never flagged as a newline.
    a_char_not_newline: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.out_valid |-> !result.end_of_row)
        else $error("character result flagged as end of row");

    // A newline result carries the newline code.
    a_newline_code: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.end_of_row |-> result.out_char == CHAR_NEWLINE)
        else $error("end of row result without newline code");
`endif

endmodule

[test/tb_character_page_composer_core.sv]
// ----------------------------------------------------------------------------
// tb_character_page_composer_core: self-checking bench of the page composer
// Drives actions through the item channel and scale writes through the config
// channel, predicts every result with a behavioral copy of the page store and
// compares each result transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_character_page_composer_core
    import cpc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROWS  = DEF_PAGE_ROWS;
    localparam int COLS  = DEF_PAGE_COLS;
    localparam int DEPTH = DEF_STACK_DEPTH;
    localparam int CUT   = DEF_ROW_CUT;

    // One result transaction as the block presents it.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CHAR_W-1:0]   ch;
        logic                ov;
        logic                eor;
        logic                eop;
    } page_result_t;

    logic clk;
    logic rst_n;

    cpc_in_if  item ();
    cpc_out_if result ();
    cpc_cfg_if cfg ();

    character_page_composer_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item.sink),
        .result (result.source),
        .cfg    (cfg.sink)
    );

    // 4 ns clock period.
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // ------------------------------------------------------------------------
    // Behavioral page model. This is the mirror of the block's state that the
    // predictor updates once per accepted transaction on the item channel.
    // ------------------------------------------------------------------------
    logic [CHAR_W-1:0]  page_mem [ROWS*COLS];
    logic [POS_W-1:0]   col_pos, row_pos;
    logic [POS_W-1:0]   saved_col [DEPTH];
    logic [POS_W-1:0]   saved_row [DEPTH];
    logic [SCALE_W-1:0] col_div, row_div;
    int                 box_c0, box_c1, box_r0, box_r1;
    int                 depth_used;
    bit                 page_open;
    int                 scan_row, scan_col, scan_len;
    bit                 scan_on;

    page_result_t expected_results [$];
    page_result_t last_prediction;

    int  mismatches;
    int  failures;
    bit  steady;       // When set, neither side idles at random.
    int  hold_cycles;  // Requested long hold-off on the result channel.

    function automatic int cell_of(logic [POS_W-1:0] pos, logic [SCALE_W-1:0] scale,
                                   int limit);
        int q;
        if (pos[POS_W-1])
            return 0;
        q = int'(pos) / ((scale == 0) ? 1 : int'(scale));
        return (q >= limit) ? limit - 1 : q;
    endfunction

    function void wipe_page();
        foreach (page_mem[k])
            page_mem[k] = CHAR_SPACE;
        col_pos = '0;
        row_pos = '0;
        box_c0  = COLS;
        box_c1  = 0;
        box_r0  = ROWS;
        box_r1  = 0;
    endfunction

    function void place_char(logic [CHAR_W-1:0] c);
        int i;
        int j;
        i = cell_of(col_pos, col_div, COLS);
        j = cell_of(row_pos, row_div, ROWS);
        page_mem[j*COLS + i] = c;
        if (i > box_c1) box_c1 = i;
        if (i < box_c0) box_c0 = i;
        if (j > box_r1) box_r1 = j;
        if (j < box_r0) box_r0 = j;
    endfunction

    // Length of a row inside the box after trailing blanks are trimmed,
    // cut to CUT+1 columns.
    function int trimmed_length(int row);
        int k;
        if (row < 0 || row >= ROWS || box_c0 > box_c1)
            return 0;
        k = box_c1;
        while (k >= box_c0 && page_mem[row*COLS + k] == CHAR_SPACE)
            k--;
        if (k < box_c0)
            return 0;
        if (k > box_c0 + CUT)
            k = box_c0 + CUT;
        return k - box_c0 + 1;
    endfunction

    // Character stored for a two-letter special name, or found = 0.
    function spec_t special_char(logic [CHAR_W-1:0] a, logic [CHAR_W-1:0] b);
        spec_t s;
        s.found = 1'b1;
        s.ch    = CHAR_SPACE;
        if ((a == "e" && b == "m") || (a == "h" && b == "y") || (a == "e" && b == "n"))
            s.ch = "-";
        else if (a == "b" && b == "u") s.ch = "o";
        else if (a == "m" && b == "u") s.ch = "x";
        else if (a == "s" && b == "q") s.ch = "]";
        else if (a == "r" && b == "u") s.ch = "_";
        else if (a == "l" && b == ".") s.ch = ".";
        else if ((a == "b" || a == "v" || a == "o") && b == "r") s.ch = "|";
        else if (a == "f" && b == "m") s.ch = "'";
        else if (a == "p" && b == "l") s.ch = "+";
        else if (a == "c" && b == "i") s.ch = "O";
        else if (a == "*" && b == "*") s.ch = "*";
        else s.found = 1'b0;
        return s;
    endfunction

    // Applies one action to the page model and returns the result it gives.
    function page_result_t compose_step(logic [ACT_W-1:0] act, logic [POS_W-1:0] amt,
                                        logic [CHAR_W-1:0] c, logic [CHAR_W-1:0] n1,
                                        logic [CHAR_W-1:0] n2);
        page_result_t r;
        spec_t        s;
        int           cc;
        r = '0;
        case (act)
            ACT_HGOTO:    col_pos = amt;
            ACT_HMOVE:    col_pos = col_pos + amt;
            ACT_VGOTO:    row_pos = amt;
            ACT_VMOVE:    row_pos = row_pos + amt;
            ACT_PUT_CHAR: if (page_open) place_char(c);
            ACT_PUT_SPEC:
            begin
                s = special_char(n1, n2);
                if (page_open && s.found)
                    place_char(s.ch);
            end
            ACT_LINE_END: col_pos = '0;
            ACT_PUSH:
            begin
                if (depth_used >= DEPTH)
                    r.status = STS_OVERFLOW;
                else
                begin
                    saved_col[depth_used] = col_pos;
                    saved_row[depth_used] = row_pos;
                    depth_used++;
                    col_pos = '0;
                    row_pos = '0;
                end
            end
            ACT_POP:
            begin
                if (depth_used <= 0)
                    r.status = STS_UNDERFLOW;
                else
                begin
                    depth_used--;
                    col_pos = saved_col[depth_used];
                    row_pos = saved_row[depth_used];
                end
            end
            ACT_NEW_PAGE:
            begin
                wipe_page();
                page_open = 1'b1;
                scan_on   = 1'b0;
                scan_row  = 0;
                scan_col  = 0;
                scan_len  = 0;
            end
            ACT_READ_NEXT:
            begin
                if (!scan_on && box_r0 > box_r1)
                begin
                    r.eop = 1'b1;
                    return r;
                end
                if (!scan_on)
                begin
                    scan_on  = 1'b1;
                    scan_row = box_r0;
                    scan_col = 0;
                    scan_len = trimmed_length(scan_row);
                end
                if (scan_col < scan_len)
                begin
                    cc = box_c0 + scan_col;
                    if (cc < 0) cc = 0;
                    if (cc >= COLS) cc = COLS - 1;
                    r.ch = page_mem[scan_row*COLS + cc];
                    r.ov = 1'b1;
                    scan_col++;
                end
                else
                begin
                    r.ch  = CHAR_NEWLINE;
                    r.eor = 1'b1;
                    scan_row++;
                    scan_col = 0;
                    if (scan_row > box_r1)
                    begin
                        r.eop    = 1'b1;
                        scan_on  = 1'b0;
                        scan_row = 0;
                        scan_len = 0;
                    end
                    else
                        scan_len = trimmed_length(scan_row);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Item sender. Called at a rising edge; returns at the edge where the
    // transaction was accepted, with valid still high so that back-to-back
    // transactions need only one assignment per step.
    // ------------------------------------------------------------------------
    task automatic send_action(logic [ACT_W-1:0] act, logic [POS_W-1:0] amt = '0,
                               logic [CHAR_W-1:0] c = '0, logic [CHAR_W-1:0] n1 = '0,
                               logic [CHAR_W-1:0] n2 = '0);
        if (!steady && $urandom_range(99) < 15)
        begin
            item.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        item.valid       <= 1'b1;
        item.action      <= act;
        item.amount      <= amt;
        item.char_code   <= c;
        item.name_first  <= n1;
        item.name_second <= n2;
        @(posedge clk);
        while (!item.ready)
            @(posedge clk);
        last_prediction = compose_step(act, amt, c, n1, n2);
        expected_results.push_back(last_prediction);
    endtask

    // Drops valid and waits until every predicted result has come back and
    // the block has had time to settle.
    task automatic drain();
        item.valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    // Writes one scale register; only called while the block is idle.
    task automatic write_scale(logic [CFG_IDX_W-1:0] idx, logic [SCALE_W-1:0] val);
        drain();
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        if (idx == CFG_COL_SCALE)
            col_div = val;
        else
            row_div = val;
    endtask

    // Reads until the end-of-page result, with a bound as a safety net.
    task automatic read_whole_page();
        int n;
        n = 0;
        do
        begin
            send_action(ACT_READ_NEXT);
            n++;
        end
        while (!last_prediction.eop && n < 20000);
    endtask

    // A position that usually lands near the top left corner of the page at
    // the current scale, now and then far off or negative.
    function automatic logic [POS_W-1:0] page_position(logic [SCALE_W-1:0] scale, int limit);
        int s;
        s = (scale == 0) ? 1 : int'(scale);
        case ($urandom_range(19))
            0:       return POS_W'($urandom);
            1:       return POS_W'(-int'($urandom_range(1, 5000)));
            default: return POS_W'(longint'(s) * $urandom_range(0, (limit < 12) ? limit : 11)
                                   + $urandom_range(0, s - 1));
        endcase
    endfunction

    // One random action, weighted toward moves, puts and reads.
    task automatic random_action();
        int          w;
        logic [7:0]  a;
        logic [7:0]  b;
        string       names;
        int          k;
        names = "emhybumusqenrul.brvrfmorplci**[]";
        w = $urandom_range(99);
        if (w < 12)
            send_action(ACT_HGOTO, page_position(col_div, COLS));
        else if (w < 22)
            send_action(ACT_VGOTO, page_position(row_div, ROWS));
        else if (w < 28)
            send_action(ACT_HMOVE, ($urandom_range(7) == 0) ? POS_W'($urandom)
                        : POS_W'(int'($urandom_range(0, 600)) - 300));
        else if (w < 33)
            send_action(ACT_VMOVE, ($urandom_range(7) == 0) ? POS_W'($urandom)
                        : POS_W'(int'($urandom_range(0, 800)) - 400));
        else if (w < 50)
            send_action(ACT_PUT_CHAR, POS_W'($urandom), CHAR_W'($urandom_range(255)));
        else if (w < 60)
        begin
            k = $urandom_range(15);
            a = names[2*k];
            b = names[2*k + 1];
            if ($urandom_range(3) == 0)
            begin
                a = CHAR_W'($urandom_range(255));
                b = CHAR_W'($urandom_range(255));
            end
            send_action(ACT_PUT_SPEC, '0, '0, a, b);
        end
        else if (w < 63)
            send_action(ACT_LINE_END, POS_W'($urandom));
        else if (w < 68)
            send_action(ACT_PUSH);
        else if (w < 73)
            send_action(ACT_POP);
        else if (w < 76)
            send_action(ACT_NEW_PAGE);
        else if (w < 78)
            send_action(ACT_W'($urandom_range(11, 15)), POS_W'($urandom),
                        CHAR_W'($urandom_range(255)), CHAR_W'($urandom_range(255)),
                        CHAR_W'($urandom_range(255)));
        else
            send_action(ACT_READ_NEXT);
    endtask

    // ------------------------------------------------------------------------
    // Result checker and receiver. Ready idles at random unless steady is set,
    // and drops while hold_cycles counts down when a test asks for back pressure.
    // ------------------------------------------------------------------------
    initial
    begin
        page_result_t got;
        page_result_t want;
        result.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (result.valid && result.ready)
            begin
                got = {result.status, result.out_char, result.out_valid,
                       result.end_of_row, result.end_of_page};
                if (expected_results.size() == 0)
                begin
                    failures++;
                    $display("ERROR: result transaction with nothing expected: %p", got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"ERROR: result mismatch status %0d/%0d char %h/%h ",
                                      "valid %b/%b eor %b/%b eop %b/%b (expected/actual)"},
                                     want.status, got.status, want.ch, got.ch, want.ov,
                                     got.ov, want.eor, got.eor, want.eop, got.eop);
                    end
                end
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                result.ready <= 1'b0;
            end
            else
                result.ready <= steady || ($urandom_range(99) >= 15);
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Before the first new page output is off: puts store nothing and a read
    // sees an empty page. Also pops on an empty stack and unused actions.
    task automatic test_output_off();
        send_action(ACT_PUT_CHAR, '0, "A");
        send_action(ACT_PUT_SPEC, '0, '0, "b", "u");
        send_action(ACT_READ_NEXT);
        send_action(ACT_POP);
        for (int k = 11; k <= 15; k++)
            send_action(ACT_W'(k), POS_W'($urandom), CHAR_W'($urandom_range(255)),
                        CHAR_W'($urandom_range(255)), CHAR_W'($urandom_range(255)));
    endtask

    // Directed corners: position extremes and wrap, clamping on both sides,
    // two special names plus unknown ones, stack overflow and underflow,
    // the row cut and a blank row in the middle of the box.
    task automatic test_directed_page();
        send_action(ACT_NEW_PAGE);
        send_action(ACT_HGOTO, 24'h800000);
        send_action(ACT_VGOTO, 24'h7FFFFF);
        send_action(ACT_PUT_CHAR, '0, 8'h00);
        send_action(ACT_HMOVE, 24'h7FFFFF);
        send_action(ACT_HMOVE, 24'h000002);
        send_action(ACT_PUT_CHAR, '0, 8'hFF);
        send_action(ACT_LINE_END);
        send_action(ACT_VGOTO, 24'd200);
        send_action(ACT_PUT_SPEC, '0, '0, "s", "q");
        send_action(ACT_HGOTO, 24'd7499);
        send_action(ACT_PUT_SPEC, '0, '0, "c", "i");
        send_action(ACT_VMOVE, 24'hFFFF9C);
        send_action(ACT_PUT_SPEC, '0, '0, "z", "z");
        send_action(ACT_PUT_SPEC, '0, '0, 8'hFF, 8'h00);
        for (int k = 0; k < DEPTH + 1; k++)
            send_action(ACT_PUSH);
        for (int k = 0; k < DEPTH + 1; k++)
            send_action(ACT_POP);
        read_whole_page();
        read_whole_page();
    endtask

    // Every special name stored in turn along one row, then read back.
    task automatic test_special_names();
        string names;
        names = "emhybumusqenrul.brvrfmorplci**[]";
        send_action(ACT_NEW_PAGE);
        for (int k = 0; k < 16; k++)
        begin
            send_action(ACT_HGOTO, POS_W'(k * 75));
            send_action(ACT_PUT_SPEC, '0, '0, names[2*k], names[2*k + 1]);
        end
        read_whole_page();
    endtask

    // Random traffic under one pair of scales, mostly well-formed pages:
    // a new page, moves and puts, then a complete read-out, with reads and
    // puts interleaved now and then.
    task automatic test_random_phase(logic [SCALE_W-1:0] cs, logic [SCALE_W-1:0] rs, int count);
        write_scale(CFG_COL_SCALE, cs);
        write_scale(CFG_ROW_SCALE, rs);
        send_action(ACT_NEW_PAGE);
        for (int k = 0; k < count; k++)
            random_action();
        read_whole_page();
    endtask

    // The receiver stops for a long stretch while the sender keeps going,
    // so the block fills up and stalls the item channel.
    task automatic test_back_pressure();
        drain();
        steady      = 1'b1;
        hold_cycles = 400;
        for (int k = 0; k < 30; k++)
            send_action(k[0] ? ACT_HMOVE : ACT_PUSH, POS_W'($urandom_range(100)));
        for (int k = 0; k < 60; k++)
            random_action();
        drain();
        steady = 1'b0;
    endtask

    initial
    begin
        rst_n            = 1'b0;
        item.valid       = 1'b0;
        item.action      = '0;
        item.amount      = '0;
        item.char_code   = '0;
        item.name_first  = '0;
        item.name_second = '0;
        cfg.valid        = 1'b0;
        cfg.index        = '0;
        cfg.data         = '0;
        mismatches       = 0;
        failures         = 0;
        steady           = 1'b0;
        hold_cycles      = 0;
        col_div          = COL_SCALE_RST;
        row_div          = ROW_SCALE_RST;
        depth_used       = 0;
        page_open        = 1'b0;
        scan_on          = 1'b0;
        scan_row         = 0;
        scan_col         = 0;
        scan_len         = 0;
        wipe_page();
        foreach (saved_col[k])
        begin
            saved_col[k] = '0;
            saved_row[k] = '0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_output_off();
        test_directed_page();
        test_special_names();
        test_random_phase(16'd75, 16'd100, 100);
        test_random_phase(16'd1, 16'd1, 50);
        test_random_phase(16'd65535, 16'd65535, 40);
        test_random_phase(16'd0, 16'd0, 40);
        steady = 1'b1;
        test_random_phase(16'd30, 16'd60, 60);
        steady = 1'b0;
        test_back_pressure();
        test_random_phase(16'($urandom_range(1, 400)), 16'($urandom_range(1, 400)), 80);

        drain();
        if (expected_results.size() != 0)
            failures++;
        if (mismatches == 0 && failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
